FILE: hw/rtl/sra_pkg.sv
package sra_pkg;

  // Number of list positions that take part in a scan.
  localparam int MODULES = 32;

  localparam int STATE_W = 8;
  localparam int SUB_W   = 16;
  localparam int IDX_W   = 5;
  localparam int COUNT_W = 6;
  localparam int MASK_W  = 32;
  localparam int BOOT_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [BOOT_W-1:0]  BOOT_MAX  = {BOOT_W{1'b1}};

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_HOLD     = 2'd0,
    CFG_BOOTING_STATE = 2'd1,
    CFG_ERROR_STATE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [STATE_W-1:0] machine_state;
    logic [SUB_W-1:0]   machine_substate;
    logic               module_valid;
    logic [IDX_W-1:0]   module_index;
    logic [SUB_W-1:0]   requested_substate;
    logic               module_bypassed;
    logic [STATE_W-1:0] module_reported_state;
    logic               last_module;
  } record_t;

  typedef struct packed {
    logic busy;
    logic later_request;
    logic error;
  } rec_flags_t;

  typedef struct packed {
    status_t            response_status;
    logic [COUNT_W-1:0] busy_count;
    logic [MASK_W-1:0]  busy_mask;
    logic               first_busy_valid;
    logic [IDX_W-1:0]   first_busy_index;
    logic               first_error_valid;
    logic [IDX_W-1:0]   first_error_index;
    logic [SUB_W-1:0]   next_substate;
    logic               next_request_valid;
    logic [IDX_W-1:0]   next_request_index;
  } result_t;

endpackage

FILE: hw/rtl/sra_record_eval.sv
module sra_record_eval import sra_pkg::*; (
  input  record_t            rec,
  input  logic [STATE_W-1:0] error_state_code,
  output rec_flags_t         flags
);

  logic counted;
  logic at_or_below;

  // Empty markers, bypassed modules and positions past the list take no part.
  assign counted = rec.module_valid && !rec.module_bypassed &&
                   (32'(rec.module_index) < 32'(MODULES));
  assign at_or_below = rec.requested_substate <= rec.machine_substate;

  assign flags.busy          = counted && at_or_below &&
                               (rec.module_reported_state != rec.machine_state);
  assign flags.later_request = counted && !at_or_below;
  assign flags.error         = counted &&
                               (rec.module_reported_state == error_state_code);

endmodule

FILE: hw/rtl/sra_accum.sv
module sra_accum import sra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  record_t            rec,
  input  rec_flags_t         flags,
  input  logic [BOOT_W-1:0]  boot_hold_cycles,
  input  logic [STATE_W-1:0] booting_state_code,
  output result_t            res
);

  logic [COUNT_W-1:0] busy_count, busy_count_next;
  logic [MASK_W-1:0]  busy_mask, busy_mask_next;
  logic               first_busy_valid, first_busy_valid_next;
  logic [IDX_W-1:0]   first_busy_index, first_busy_index_next;
  logic               first_error_valid, first_error_valid_next;
  logic [IDX_W-1:0]   first_error_index, first_error_index_next;
  logic [SUB_W-1:0]   next_substate, next_substate_next;
  logic               next_valid, next_valid_next;
  logic [IDX_W-1:0]   next_index, next_index_next;
  logic [BOOT_W-1:0]  boot_count, boot_count_next;
  logic               booting;
  logic               boot_hold_busy;
  logic               take_next;

  always_comb begin
    busy_count_next        = busy_count;
    busy_mask_next         = busy_mask;
    first_busy_valid_next  = first_busy_valid;
    first_busy_index_next  = first_busy_index;
    first_error_valid_next = first_error_valid;
    first_error_index_next = first_error_index;
    next_substate_next     = next_substate;
    next_valid_next        = next_valid;
    next_index_next        = next_index;

    if (flags.busy) begin
      if (busy_count != COUNT_MAX) begin
        busy_count_next = busy_count + COUNT_W'(1);
      end
      busy_mask_next = busy_mask | (MASK_W'(1) << rec.module_index);
      if (!first_busy_valid) begin
        first_busy_valid_next = 1'b1;
        first_busy_index_next = rec.module_index;
      end
    end
    if (take_next) begin
      next_valid_next    = 1'b1;
      next_substate_next = rec.requested_substate;
      next_index_next    = rec.module_index;
    end
    if (flags.error && !first_error_valid) begin
      first_error_valid_next = 1'b1;
      first_error_index_next = rec.module_index;
    end
  end

  // A strictly lower request replaces the held one, so the earliest record wins ties.
  assign take_next = flags.later_request &&
                     (!next_valid || (rec.requested_substate < next_substate));

  // The boot counter advances at most once per scan, on a last record in the booting state, before it is compared.
  assign booting = rec.machine_state == booting_state_code;
  always_comb begin
    boot_count_next = boot_count;
    if (booting && boot_count != BOOT_MAX) begin
      boot_count_next = boot_count + BOOT_W'(1);
    end
  end
  assign boot_hold_busy = booting && (boot_count_next < boot_hold_cycles);

  always_comb begin
    res.busy_count         = busy_count_next;
    res.busy_mask          = busy_mask_next;
    res.first_busy_valid   = first_busy_valid_next;
    res.first_busy_index   = first_busy_index_next;
    res.first_error_valid  = first_error_valid_next;
    res.first_error_index  = first_error_index_next;
    res.next_substate      = next_substate_next;
    res.next_request_valid = next_valid_next;
    res.next_request_index = next_index_next;
    if (first_error_valid_next) begin
      res.response_status = STATUS_ERROR;
    end else if (busy_count_next != '0 || boot_hold_busy) begin
      res.response_status = STATUS_BUSY;
    end else begin
      res.response_status = STATUS_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_count        <= '0;
      busy_mask         <= '0;
      first_busy_valid  <= 1'b0;
      first_busy_index  <= '0;
      first_error_valid <= 1'b0;
      first_error_index <= '0;
      next_substate     <= '0;
      next_valid        <= 1'b0;
      next_index        <= '0;
      boot_count        <= '0;
    end else if (fire) begin
      if (rec.last_module) begin
        busy_count        <= '0;
        busy_mask         <= '0;
        first_busy_valid  <= 1'b0;
        first_busy_index  <= '0;
        first_error_valid <= 1'b0;
        first_error_index <= '0;
        next_substate     <= '0;
        next_valid        <= 1'b0;
        next_index        <= '0;
        boot_count        <= boot_count_next;
      end else begin
        busy_count        <= busy_count_next;
        busy_mask         <= busy_mask_next;
        first_busy_valid  <= first_busy_valid_next;
        first_busy_index  <= first_busy_index_next;
        first_error_valid <= first_error_valid_next;
        first_error_index <= first_error_index_next;
        next_substate     <= next_substate_next;
        next_valid        <= next_valid_next;
        next_index        <= next_index_next;
      end
    end
  end

endmodule

FILE: hw/rtl/step_response_aggregator.sv
// Takes one module status record per request and, on the record marked last_module,
// gives one summary request: status (error over busy over done), busy count and
// mask, first busy and first error module, and the lowest later substate with the
// first module asking for it. Records are registered on entry and folded into the
// scan accumulators in the next cycle, so a record can be taken every cycle; a
// summary is registered as its last record is folded in and is held in an
// output register while the next scan's records keep flowing in. Only a last
// record waits when a previous summary has not been taken. While the machine state
// equals booting_state_code on a last record, a saturating per-scan counter keeps
// the status at busy until it reaches boot_hold_cycles; only reset clears it.
module step_response_aggregator import sra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [STATE_W-1:0]   machine_state,
  input  logic [SUB_W-1:0]     machine_substate,
  input  logic                 module_valid,
  input  logic [IDX_W-1:0]     module_index,
  input  logic [SUB_W-1:0]     requested_substate,
  input  logic                 module_bypassed,
  input  logic [STATE_W-1:0]   module_reported_state,
  input  logic                 last_module,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           response_status,
  output logic [COUNT_W-1:0]   busy_count,
  output logic [MASK_W-1:0]    busy_mask,
  output logic                 first_busy_valid,
  output logic [IDX_W-1:0]     first_busy_index,
  output logic                 first_error_valid,
  output logic [IDX_W-1:0]     first_error_index,
  output logic [SUB_W-1:0]     next_substate,
  output logic                 next_request_valid,
  output logic [IDX_W-1:0]     next_request_index
);

  logic [BOOT_W-1:0]  boot_hold_cycles;
  logic [STATE_W-1:0] booting_state_code;
  logic [STATE_W-1:0] error_state_code;

  record_t    rec;
  logic       rec_valid;
  rec_flags_t flags;
  result_t    res;
  result_t    res_q;
  logic       out_free;
  logic       fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_hold_cycles   <= '0;
      booting_state_code <= STATE_W'(1);
      error_state_code   <= {STATE_W{1'b1}};
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BOOT_HOLD:     boot_hold_cycles   <= cfg_data[BOOT_W-1:0];
        CFG_BOOTING_STATE: booting_state_code <= cfg_data[STATE_W-1:0];
        CFG_ERROR_STATE:   error_state_code   <= cfg_data[STATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign fire     = rec_valid && (!rec.last_module || out_free);
  assign in_ready = !rec_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_ready) begin
      rec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rec.machine_state         <= machine_state;
      rec.machine_substate      <= machine_substate;
      rec.module_valid          <= module_valid;
      rec.module_index          <= module_index;
      rec.requested_substate    <= requested_substate;
      rec.module_bypassed       <= module_bypassed;
      rec.module_reported_state <= module_reported_state;
      rec.last_module           <= last_module;
    end
  end

  sra_record_eval u_eval (
    .rec              (rec),
    .error_state_code (error_state_code),
    .flags            (flags)
  );

  sra_accum u_accum (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .rec                (rec),
    .flags              (flags),
    .boot_hold_cycles   (boot_hold_cycles),
    .booting_state_code (booting_state_code),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && rec.last_module) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && rec.last_module) begin
      res_q <= res;
    end
  end

  assign response_status    = res_q.response_status;
  assign busy_count         = res_q.busy_count;
  assign busy_mask          = res_q.busy_mask;
  assign first_busy_valid   = res_q.first_busy_valid;
  assign first_busy_index   = res_q.first_busy_index;
  assign first_error_valid  = res_q.first_error_valid;
  assign first_error_index  = res_q.first_error_index;
  assign next_substate      = res_q.next_substate;
  assign next_request_valid = res_q.next_request_valid;
  assign next_request_index = res_q.next_request_index;

endmodule

FILE: test/step_response_aggregator_tb.sv
module step_response_aggregator_tb;
  import sra_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_MISMATCHES = 40;
  localparam int SCAN_ITEMS     = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BOOT_HOLD;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [STATE_W-1:0]   machine_state;
  logic [SUB_W-1:0]     machine_substate;
  logic                 module_valid;
  logic [IDX_W-1:0]     module_index;
  logic [SUB_W-1:0]     requested_substate;
  logic                 module_bypassed;
  logic [STATE_W-1:0]   module_reported_state;
  logic                 last_module;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           response_status;
  logic [COUNT_W-1:0]   busy_count;
  logic [MASK_W-1:0]    busy_mask;
  logic                 first_busy_valid;
  logic [IDX_W-1:0]     first_busy_index;
  logic                 first_error_valid;
  logic [IDX_W-1:0]     first_error_index;
  logic [SUB_W-1:0]     next_substate;
  logic                 next_request_valid;
  logic [IDX_W-1:0]     next_request_index;

  record_t send_rec = '0;

  assign machine_state         = send_rec.machine_state;
  assign machine_substate      = send_rec.machine_substate;
  assign module_valid          = send_rec.module_valid;
  assign module_index          = send_rec.module_index;
  assign requested_substate    = send_rec.requested_substate;
  assign module_bypassed       = send_rec.module_bypassed;
  assign module_reported_state = send_rec.module_reported_state;
  assign last_module           = send_rec.last_module;

  step_response_aggregator dut (.*);

  always #2 clk = ~clk;

  // Register copies kept by the predictor.
  logic [BOOT_W-1:0]  hold_scans = '0;
  logic [STATE_W-1:0] boot_code  = 8'd1;
  logic [STATE_W-1:0] err_code   = 8'hFF;

  // Scan tallies; all but boot_scans clear after every summary.
  logic [BOOT_W-1:0]  boot_scans  = '0;
  logic [COUNT_W-1:0] busy_tally  = '0;
  logic [MASK_W-1:0]  busy_bits   = '0;
  logic               busy_seen   = 1'b0;
  logic [IDX_W-1:0]   busy_first  = '0;
  logic               err_seen    = 1'b0;
  logic [IDX_W-1:0]   err_first   = '0;
  logic               later_seen  = 1'b0;
  logic [SUB_W-1:0]   later_sub   = '0;
  logic [IDX_W-1:0]   later_first = '0;

  record_t pending_records[$];
  result_t expected_summaries[$];

  bit failed = 1'b0;
  int mismatch_lines = 0;
  bit idling_on = 1'b1;
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  task automatic predict_record(record_t r);
    result_t summary;
    logic    hold_busy;
    if (r.module_valid && int'(r.module_index) < MODULES && !r.module_bypassed) begin
      if (r.requested_substate <= r.machine_substate) begin
        if (r.module_reported_state != r.machine_state) begin
          if (busy_tally != COUNT_MAX) busy_tally = busy_tally + 1'b1;
          busy_bits[r.module_index] = 1'b1;
          if (!busy_seen) begin
            busy_seen  = 1'b1;
            busy_first = r.module_index;
          end
        end
      end else if (!later_seen || r.requested_substate < later_sub) begin
        later_seen  = 1'b1;
        later_sub   = r.requested_substate;
        later_first = r.module_index;
      end
      if (r.module_reported_state == err_code && !err_seen) begin
        err_seen  = 1'b1;
        err_first = r.module_index;
      end
    end
    if (r.last_module) begin
      hold_busy = 1'b0;
      // The boot decision looks only at the state carried by the closing record.
      if (r.machine_state == boot_code) begin
        if (boot_scans != BOOT_MAX) boot_scans = boot_scans + 1'b1;
        hold_busy = boot_scans < hold_scans;
      end
      summary.response_status    = err_seen ? STATUS_ERROR :
                                   (busy_tally != 0 || hold_busy) ? STATUS_BUSY : STATUS_DONE;
      summary.busy_count         = busy_tally;
      summary.busy_mask          = busy_bits;
      summary.first_busy_valid   = busy_seen;
      summary.first_busy_index   = busy_first;
      summary.first_error_valid  = err_seen;
      summary.first_error_index  = err_first;
      summary.next_substate      = later_sub;
      summary.next_request_valid = later_seen;
      summary.next_request_index = later_first;
      expected_summaries.push_back(summary);
      busy_tally  = '0;
      busy_bits   = '0;
      busy_seen   = 1'b0;
      busy_first  = '0;
      err_seen    = 1'b0;
      err_first   = '0;
      later_seen  = 1'b0;
      later_sub   = '0;
      later_first = '0;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failed = 1'b1;
      if (mismatch_lines < MAX_MISMATCHES)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_lines++;
    end
  endtask

  task automatic check_summary(result_t want);
    check_field("response_status", want.response_status, response_status);
    check_field("busy_count", want.busy_count, busy_count);
    check_field("busy_mask", want.busy_mask, busy_mask);
    check_field("first_busy_valid", want.first_busy_valid, first_busy_valid);
    check_field("first_busy_index", want.first_busy_index, first_busy_index);
    check_field("first_error_valid", want.first_error_valid, first_error_valid);
    check_field("first_error_index", want.first_error_index, first_error_index);
    check_field("next_substate", want.next_substate, next_substate);
    check_field("next_request_valid", want.next_request_valid, next_request_valid);
    check_field("next_request_index", want.next_request_index, next_request_index);
  endtask

  // Request side: a new record goes out only once the current one is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_record(send_rec);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_records.size() != 0) begin
          send_rec <= pending_records.pop_front();
          in_valid <= 1'b1;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Summary side.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          failed = 1'b1;
          if (mismatch_lines < MAX_MISMATCHES)
            $display("%0t: summary with none expected, status %0h", $time, response_status);
          mismatch_lines++;
        end else begin
          check_summary(expected_summaries.pop_front());
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic record_t make_record(logic [STATE_W-1:0] st, logic [SUB_W-1:0] sub,
                                          logic vld, logic [IDX_W-1:0] idx,
                                          logic [SUB_W-1:0] req, logic byp,
                                          logic [STATE_W-1:0] rep, logic last);
    record_t r;
    r.machine_state         = st;
    r.machine_substate      = sub;
    r.module_valid          = vld;
    r.module_index          = idx;
    r.requested_substate    = req;
    r.module_bypassed       = byp;
    r.module_reported_state = rep;
    r.last_module           = last;
    return r;
  endfunction

  function automatic logic [SUB_W-1:0] clamp_sub(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return SUB_W'(v);
  endfunction

  function automatic logic [STATE_W-1:0] pick_state();
    case ($urandom_range(0, 4))
      0: return boot_code;
      1: return err_code;
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [SUB_W-1:0] pick_sub();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return 16'($urandom);
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic push_random_scans(int budget);
    int made;
    int len;
    int start;
    int kind;
    bit storm;
    bit shuffled;
    bit drift;
    logic               vld;
    logic               byp;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] st;
    logic [STATE_W-1:0] rep;
    logic [SUB_W-1:0]   sub;
    logic [SUB_W-1:0]   req;
    made = 0;
    while (made < budget) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        pending_records.push_back(make_record(8'($urandom), 16'($urandom), 1'b0,
                                              5'($urandom), 16'($urandom), 1'($urandom),
                                              8'($urandom), 1'b1));
        made++;
      end else begin
        if (kind < 12) len = $urandom_range(1, 6);
        else if (kind < 15) len = $urandom_range(7, MODULES);
        else if ($urandom_range(0, 2) == 0) len = $urandom_range(64, 70);
        else len = $urandom_range(33, 40);
        // A scan of at least 64 records is made mostly busy to saturate the count.
        storm    = len >= 64;
        shuffled = $urandom_range(0, 3) == 0;
        drift    = $urandom_range(0, 15) == 0;
        start    = $urandom_range(0, MODULES - 1);
        st       = pick_state();
        sub      = pick_sub();
        for (int i = 0; i < len; i++) begin
          if (drift) begin
            st  = pick_state();
            sub = pick_sub();
          end
          idx = shuffled ? 5'($urandom) : 5'((start + i) % MODULES);
          case ($urandom_range(0, 7))
            0: req = 16'($urandom);
            1: req = '0;
            2: req = '1;
            3: req = sub;
            4, 5: req = clamp_sub(int'(sub) - int'($urandom_range(1, 20)));
            default: req = clamp_sub(int'(sub) + int'($urandom_range(1, 4)));
          endcase
          case ($urandom_range(0, 7))
            0, 1, 2: rep = st;
            3: rep = err_code;
            4: rep = boot_code;
            default: rep = 8'($urandom);
          endcase
          vld = $urandom_range(0, 15) != 0;
          byp = $urandom_range(0, 7) == 0;
          if (storm && $urandom_range(0, 15) != 0) begin
            req = clamp_sub(int'(sub) - int'($urandom_range(0, 3)));
            rep = st + 1'b1;
            vld = 1'b1;
            byp = 1'b0;
          end
          pending_records.push_back(make_record(st, sub, vld, idx, req, byp, rep,
                                                i == len - 1));
        end
        made += len;
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    case (which)
      CFG_BOOT_HOLD:     hold_scans = value;
      CFG_BOOTING_STATE: boot_code  = value[STATE_W-1:0];
      CFG_ERROR_STATE:   err_code   = value[STATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CFG_W-1:0] hold, logic [STATE_W-1:0] boot,
                            logic [STATE_W-1:0] err);
    write_reg(CFG_BOOT_HOLD, hold);
    write_reg(CFG_BOOTING_STATE, CFG_W'(boot));
    write_reg(CFG_ERROR_STATE, CFG_W'(err));
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Holds the sender back until every outstanding summary is in, then lets the
  // pipeline settle so a register write cannot land on a record in flight.
  task automatic drain_requests();
    do @(negedge clk);
    while (pending_records.size() != 0 || in_valid || expected_summaries.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed scans under the reset register values.
    pending_records.push_back(make_record(8'd9, 16'd3, 1'b0, 5'd0, 16'd0, 1'b0, 8'd0, 1'b1));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd0, 16'd100, 1'b0, 8'd5, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd1, 16'd50, 1'b0, 8'd7, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd31, 16'd200, 1'b0, 8'd5, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd2, 16'd150, 1'b0, 8'd5, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd3, 16'd150, 1'b0, 8'd5, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd4, 16'd0, 1'b1, 8'hFF, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b1, 5'd5, 16'd300, 1'b0, 8'hFF, 1'b0));
    pending_records.push_back(make_record(8'd5, 16'd100, 1'b0, 5'd6, 16'd0, 1'b0, 8'hFF, 1'b1));
    pending_records.push_back(make_record(8'hFF, 16'hFFFF, 1'b1, 5'd31, 16'hFFFF, 1'b0,
                                          8'd0, 1'b0));
    pending_records.push_back(make_record(8'hFF, 16'hFFFF, 1'b1, 5'd0, 16'd0, 1'b0,
                                          8'hFF, 1'b1));
    pending_records.push_back(make_record(8'd0, 16'd0, 1'b1, 5'd10, 16'd0, 1'b0, 8'd0, 1'b0));
    pending_records.push_back(make_record(8'd0, 16'd0, 1'b1, 5'd11, 16'hFFFF, 1'b0,
                                          8'd0, 1'b1));
    pending_records.push_back(make_record(8'd1, 16'd7, 1'b1, 5'd12, 16'd7, 1'b0, 8'd1, 1'b1));
    // The same module listed twice counts twice.
    pending_records.push_back(make_record(8'd3, 16'd10, 1'b1, 5'd7, 16'd1, 1'b0, 8'd4, 1'b0));
    pending_records.push_back(make_record(8'd3, 16'd10, 1'b1, 5'd7, 16'd2, 1'b0, 8'd4, 1'b1));
    // Each record is judged against its own machine state; the last one decides boot.
    pending_records.push_back(make_record(8'd2, 16'd10, 1'b1, 5'd0, 16'd1, 1'b0, 8'd2, 1'b0));
    pending_records.push_back(make_record(8'd3, 16'd10, 1'b1, 5'd1, 16'd1, 1'b0, 8'd2, 1'b0));
    pending_records.push_back(make_record(8'd1, 16'd20, 1'b1, 5'd2, 16'd15, 1'b0, 8'd1, 1'b1));
    drain_requests();

    set_config(16'd3, 8'h10, 8'hEE);
    push_random_scans(SCAN_ITEMS);
    drain_requests();

    set_config(16'd0, 8'h00, 8'h00);
    push_random_scans(SCAN_ITEMS);
    drain_requests();

    set_config(16'hFFFF, 8'hFF, 8'hFF);
    push_random_scans(SCAN_ITEMS);
    drain_requests();

    set_config(16'd5, 8'd3, 8'h80);
    idling_on = 1'b0;
    push_random_scans(SCAN_ITEMS);
    drain_requests();

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
